/* rtl/lcr_pkg.sv */
// ----------------------------------------------------------------------------
// lcr_pkg
// Types, constants and helpers shared by the load cell serial reader.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int DATA_BITS  = 24;
  localparam int SAMPLE_W   = 24;
  localparam int HALF_W     = 10;
  localparam int WAIT_W     = 32;
  localparam int FRAME_W    = 24;
  localparam int GAIN_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int BIT_CNT_W  = $clog2(DATA_BITS + 4);
  localparam int EXT_W      = (DATA_BITS > SAMPLE_W) ? DATA_BITS : SAMPLE_W;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  localparam logic [HALF_W-1:0]  RST_HALF_PERIOD = HALF_W'(10);
  localparam logic [WAIT_W-1:0]  RST_READY_TMO   = WAIT_W'(1000000);
  localparam logic [FRAME_W-1:0] RST_FRAME_LIMIT = FRAME_W'(2500);
  localparam logic [GAIN_W-1:0]  RST_GAIN_PULSES = GAIN_W'(3);

  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_READY_TMO   = 2'd1;
  localparam logic [1:0] REG_FRAME_LIMIT = 2'd2;
  localparam logic [1:0] REG_GAIN_PULSES = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERRUN = 2'd2;

  typedef struct packed {
    logic data_line;
    logic start_req;
  } in_item_t;

  typedef struct packed {
    logic                       serial_clock;
    logic                       busy_res;
    logic                       done_res;
    logic signed [SAMPLE_W-1:0] sample;
    logic [STATUS_W-1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [HALF_W-1:0]  clock_half_period;
    logic [WAIT_W-1:0]  ready_timeout;
    logic [FRAME_W-1:0] frame_limit;
    logic [GAIN_W-1:0]  gain_pulses;
  } cfg_t;

  // Sign-extend the shifted word and clamp it to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] finish_sample(
    input logic [DATA_BITS-1:0] w
  );
    logic signed [EXT_W-1:0] e;
    logic signed [EXT_W-1:0] smax;
    logic signed [EXT_W-1:0] smin;
    logic signed [SAMPLE_W-1:0] r;
    e    = EXT_W'($signed(w));
    smax = EXT_W'($signed({1'b0, {(SAMPLE_W-1){1'b1}}}));
    smin = EXT_W'($signed({1'b1, {(SAMPLE_W-1){1'b0}}}));
    if (e > smax) begin
      r = smax[SAMPLE_W-1:0];
    end else if (e < smin) begin
      r = smin[SAMPLE_W-1:0];
    end else begin
      r = e[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/lcr_regs.sv */
// ----------------------------------------------------------------------------
// lcr_regs
// APB register file holding the reader's timing and gain configuration.
// ----------------------------------------------------------------------------
module lcr_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lcr_pkg::APB_AW-1:0] paddr,
  input  logic [lcr_pkg::APB_DW-1:0] pwdata,
  output logic [lcr_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output lcr_pkg::cfg_t             cfg_o
);

  lcr_pkg::cfg_t cfg_q;
  logic [1:0]    idx;
  logic          wr_en;

  assign idx    = paddr[lcr_pkg::APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_half_period <= lcr_pkg::RST_HALF_PERIOD;
      cfg_q.ready_timeout     <= lcr_pkg::RST_READY_TMO;
      cfg_q.frame_limit       <= lcr_pkg::RST_FRAME_LIMIT;
      cfg_q.gain_pulses       <= lcr_pkg::RST_GAIN_PULSES;
    end else if (wr_en) begin
      case (idx)
        lcr_pkg::REG_HALF_PERIOD: cfg_q.clock_half_period <= pwdata[lcr_pkg::HALF_W-1:0];
        lcr_pkg::REG_READY_TMO:   cfg_q.ready_timeout     <= pwdata[lcr_pkg::WAIT_W-1:0];
        lcr_pkg::REG_FRAME_LIMIT: cfg_q.frame_limit       <= pwdata[lcr_pkg::FRAME_W-1:0];
        lcr_pkg::REG_GAIN_PULSES: cfg_q.gain_pulses       <= pwdata[lcr_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lcr_pkg::REG_HALF_PERIOD: prdata = lcr_pkg::APB_DW'(cfg_q.clock_half_period);
      lcr_pkg::REG_READY_TMO:   prdata = lcr_pkg::APB_DW'(cfg_q.ready_timeout);
      lcr_pkg::REG_FRAME_LIMIT: prdata = lcr_pkg::APB_DW'(cfg_q.frame_limit);
      lcr_pkg::REG_GAIN_PULSES: prdata = lcr_pkg::APB_DW'(cfg_q.gain_pulses);
      default:                  prdata = '0;
    endcase
  end

endmodule

/* rtl/load_cell_adc_serial_reader.sv */
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader
// Tick-driven readout of a 24-bit serial load cell converter.
// ----------------------------------------------------------------------------
// Every input word is one time tick and yields exactly one output word. The
// block takes one word per clock cycle while the output side keeps up: the
// sequencer state and a single output register are updated in the same cycle
// an input word is accepted, so the figure is set by that one register stage
// and the output handshake. After a start request the block waits for the
// data line to fall, clocks out the data bits and the gain pulses, and
// reports the sample or a timeout or overrun status on the finishing tick.
module load_cell_adc_serial_reader (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lcr_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lcr_pkg::out_item_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcr_pkg::APB_AW-1:0] paddr,
  input  logic [lcr_pkg::APB_DW-1:0] pwdata,
  output logic [lcr_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SHIFT
  } phase_e;

  lcr_pkg::cfg_t cfg;

  phase_e                          phase_q, phase_d;
  logic [lcr_pkg::BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [lcr_pkg::DATA_BITS-1:0]   shift_q, shift_d;
  logic [lcr_pkg::WAIT_W-1:0]      wait_cnt_q, wait_cnt_d;
  logic [lcr_pkg::FRAME_W-1:0]     frame_cnt_q, frame_cnt_d;
  logic [lcr_pkg::HALF_W-1:0]      half_cnt_q, half_cnt_d;
  logic                            level_q, level_d;
  lcr_pkg::out_item_t              out_q, out_d;
  logic                            out_valid_q;

  logic                            in_fire;
  logic [lcr_pkg::HALF_W-1:0]      hp;
  logic [lcr_pkg::HALF_W:0]        half_inc;
  logic [lcr_pkg::BIT_CNT_W-1:0]   bit_inc;
  logic [lcr_pkg::BIT_CNT_W-1:0]   bit_end;

  lcr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hp       = (cfg.clock_half_period == '0) ? lcr_pkg::HALF_W'(1)
                                                  : cfg.clock_half_period;
  assign half_inc = {1'b0, half_cnt_q} + (lcr_pkg::HALF_W + 1)'(1);
  assign bit_inc  = bit_cnt_q + lcr_pkg::BIT_CNT_W'(1);
  assign bit_end  = lcr_pkg::BIT_CNT_W'(lcr_pkg::DATA_BITS)
                  + lcr_pkg::BIT_CNT_W'(cfg.gain_pulses);

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    wait_cnt_d   = wait_cnt_q;
    frame_cnt_d  = frame_cnt_q;
    half_cnt_d   = half_cnt_q;
    level_d      = level_q;
    out_d        = '0;

    case (phase_q)
      PH_IDLE: begin
        if (in_data_i.start_req) begin
          phase_d    = PH_WAIT;
          wait_cnt_d = '0;
        end
      end
      PH_WAIT: begin
        if (!in_data_i.data_line) begin
          phase_d     = PH_SHIFT;
          bit_cnt_d   = '0;
          shift_d     = '0;
          frame_cnt_d = '0;
          half_cnt_d  = '0;
          level_d     = 1'b1;
        end else if (wait_cnt_q >= cfg.ready_timeout) begin
          phase_d        = PH_IDLE;
          out_d.done_res = 1'b1;
          out_d.status   = lcr_pkg::STATUS_TIMEOUT;
        end else begin
          wait_cnt_d = wait_cnt_q + lcr_pkg::WAIT_W'(1);
        end
      end
      PH_SHIFT: begin
        out_d.serial_clock = level_q;
        if (frame_cnt_q != lcr_pkg::FRAME_MAX) begin
          frame_cnt_d = frame_cnt_q + lcr_pkg::FRAME_W'(1);
        end
        if (half_inc >= {1'b0, hp}) begin
          half_cnt_d = '0;
          if (level_q) begin
            if (bit_cnt_q < lcr_pkg::BIT_CNT_W'(lcr_pkg::DATA_BITS)) begin
              shift_d = {shift_q[lcr_pkg::DATA_BITS-2:0], in_data_i.data_line};
            end
            level_d = 1'b0;
          end else begin
            bit_cnt_d = bit_inc;
            if (bit_inc >= bit_end) begin
              phase_d        = PH_IDLE;
              out_d.done_res = 1'b1;
              if (frame_cnt_d > cfg.frame_limit) begin
                out_d.status = lcr_pkg::STATUS_OVERRUN;
              end else begin
                out_d.sample = lcr_pkg::finish_sample(shift_q);
              end
            end else begin
              level_d = 1'b1;
            end
          end
        end else begin
          half_cnt_d = half_inc[lcr_pkg::HALF_W-1:0];
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    out_d.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      wait_cnt_q  <= '0;
      frame_cnt_q <= '0;
      half_cnt_q  <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        bit_cnt_q   <= bit_cnt_d;
        shift_q     <= shift_d;
        wait_cnt_q  <= wait_cnt_d;
        frame_cnt_q <= frame_cnt_d;
        half_cnt_q  <= half_cnt_d;
        level_q     <= level_d;
        out_q       <= out_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* rtl/lcr_checker.sv */
// ----------------------------------------------------------------------------
// lcr_checker
// Port-level checks for the load cell serial reader, bound to the top level.
// ----------------------------------------------------------------------------
module lcr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lcr_pkg::out_item_t  out_data_o
);

  // Hold the result word while the sink stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("finished read still busy");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != lcr_pkg::STATUS_OK |-> out_data_o.done_res)
    else $error("status without done");

  a_sample_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sample != '0
      |-> out_data_o.done_res && out_data_o.status == lcr_pkg::STATUS_OK)
    else $error("sample outside a good finish");

endmodule

bind load_cell_adc_serial_reader lcr_checker u_lcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* verif/lcr_readout_checker.sv */
// ----------------------------------------------------------------------------
// lcr_readout_checker
// Predicts every output word of the load cell serial reader from the input
// words and register writes it sees, and compares the outputs field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcr_readout_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  lcr_pkg::in_item_t          in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  lcr_pkg::out_item_t         out_data_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [lcr_pkg::APB_AW-1:0] paddr_i,
  input  logic [lcr_pkg::APB_DW-1:0] pwdata_i,
  output int unsigned                mismatches_o,
  output int unsigned                pending_o,
  output int unsigned                words_o,
  output int unsigned                samples_o,
  output int unsigned                timeouts_o,
  output int unsigned                overruns_o
);

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WAIT,
    SEQ_CLOCKING
  } seq_phase_e;

  lcr_pkg::cfg_t                    cfg;
  seq_phase_e                       phase_q;
  logic [lcr_pkg::BIT_CNT_W-1:0]    pulses_done;
  logic [lcr_pkg::DATA_BITS-1:0]    shifted;
  logic [lcr_pkg::WAIT_W-1:0]       wait_ticks;
  logic [lcr_pkg::FRAME_W-1:0]      frame_ticks;
  logic [lcr_pkg::HALF_W-1:0]       half_ticks;
  logic                             clk_level;
  lcr_pkg::out_item_t               predicted_ticks[$];
  lcr_pkg::out_item_t               want;

  function automatic lcr_pkg::out_item_t advance_reader(input lcr_pkg::in_item_t w);
    lcr_pkg::out_item_t         r;
    logic [lcr_pkg::HALF_W-1:0] hp;
    r  = '0;
    hp = (cfg.clock_half_period == '0) ? lcr_pkg::HALF_W'(1) : cfg.clock_half_period;
    case (phase_q)
      SEQ_IDLE: begin
        if (w.start_req) begin
          phase_q    = SEQ_WAIT;
          wait_ticks = '0;
        end
      end
      SEQ_WAIT: begin
        if (!w.data_line) begin
          phase_q     = SEQ_CLOCKING;
          pulses_done = '0;
          shifted     = '0;
          frame_ticks = '0;
          half_ticks  = '0;
          clk_level   = 1'b1;
        end else if (wait_ticks >= cfg.ready_timeout) begin
          phase_q    = SEQ_IDLE;
          r.done_res = 1'b1;
          r.status   = lcr_pkg::STATUS_TIMEOUT;
        end else begin
          wait_ticks = wait_ticks + lcr_pkg::WAIT_W'(1);
        end
      end
      default: begin
        r.serial_clock = clk_level;
        if (frame_ticks != lcr_pkg::FRAME_MAX) begin
          frame_ticks = frame_ticks + lcr_pkg::FRAME_W'(1);
        end
        half_ticks = half_ticks + lcr_pkg::HALF_W'(1);
        if (half_ticks >= hp) begin
          half_ticks = '0;
          if (clk_level) begin
            if (pulses_done < lcr_pkg::BIT_CNT_W'(lcr_pkg::DATA_BITS)) begin
              shifted = {shifted[lcr_pkg::DATA_BITS-2:0], w.data_line};
            end
            clk_level = 1'b0;
          end else begin
            pulses_done = pulses_done + lcr_pkg::BIT_CNT_W'(1);
            if (pulses_done >= lcr_pkg::BIT_CNT_W'(lcr_pkg::DATA_BITS)
                             + lcr_pkg::BIT_CNT_W'(cfg.gain_pulses)) begin
              phase_q    = SEQ_IDLE;
              r.done_res = 1'b1;
              if (frame_ticks > cfg.frame_limit) begin
                r.status = lcr_pkg::STATUS_OVERRUN;
              end else begin
                r.sample = lcr_pkg::finish_sample(shifted);
              end
            end else begin
              clk_level = 1'b1;
            end
          end
        end
      end
    endcase
    r.busy_res = (phase_q != SEQ_IDLE);
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.clock_half_period = lcr_pkg::RST_HALF_PERIOD;
      cfg.ready_timeout     = lcr_pkg::RST_READY_TMO;
      cfg.frame_limit       = lcr_pkg::RST_FRAME_LIMIT;
      cfg.gain_pulses       = lcr_pkg::RST_GAIN_PULSES;
      phase_q               = SEQ_IDLE;
      pulses_done           = '0;
      shifted               = '0;
      wait_ticks            = '0;
      frame_ticks           = '0;
      half_ticks            = '0;
      clk_level             = 1'b0;
      predicted_ticks.delete();
      mismatches_o          = 0;
      pending_o             = 0;
      words_o               = 0;
      samples_o             = 0;
      timeouts_o            = 0;
      overruns_o            = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predicted_ticks.push_back(advance_reader(in_data_i));
        words_o++;
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_ticks.size() == 0) begin
          $error("output word with no input word outstanding");
          mismatches_o++;
        end else begin
          want = predicted_ticks.pop_front();
          report_field("serial_clock", 32'(want.serial_clock), 32'(out_data_i.serial_clock));
          report_field("busy_res", 32'(want.busy_res), 32'(out_data_i.busy_res));
          report_field("done_res", 32'(want.done_res), 32'(out_data_i.done_res));
          report_field("sample", 32'(want.sample), 32'(out_data_i.sample));
          report_field("status", 32'(want.status), 32'(out_data_i.status));
          if (want.done_res) begin
            case (want.status)
              lcr_pkg::STATUS_OK:      samples_o++;
              lcr_pkg::STATUS_TIMEOUT: timeouts_o++;
              lcr_pkg::STATUS_OVERRUN: overruns_o++;
              default: ;
            endcase
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[lcr_pkg::APB_AW-1:2])
          lcr_pkg::REG_HALF_PERIOD:
            cfg.clock_half_period = pwdata_i[lcr_pkg::HALF_W-1:0];
          lcr_pkg::REG_READY_TMO:
            cfg.ready_timeout     = pwdata_i[lcr_pkg::WAIT_W-1:0];
          lcr_pkg::REG_FRAME_LIMIT:
            cfg.frame_limit       = pwdata_i[lcr_pkg::FRAME_W-1:0];
          lcr_pkg::REG_GAIN_PULSES:
            cfg.gain_pulses       = pwdata_i[lcr_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      pending_o = predicted_ticks.size();
    end
  end

endmodule

/* verif/load_cell_adc_serial_reader_test.sv */
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_test
// Drives tick words and register writes into the load cell serial reader:
// scripted reads over the corner settings, then random reads, timeouts,
// overruns and noise bursts, with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_test;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_TICKS = 800;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i;
  logic                          in_ready_o;
  lcr_pkg::in_item_t             in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  lcr_pkg::out_item_t            out_data_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lcr_pkg::APB_AW-1:0]    paddr;
  logic [lcr_pkg::APB_DW-1:0]    pwdata;
  logic [lcr_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           words_seen;
  int unsigned           samples;
  int unsigned           timeouts;
  int unsigned           overruns;

  int unsigned           cycle_count = 0;
  int unsigned           words_sent = 0;
  int unsigned           settings_made = 0;
  bit                    steady = 1'b0;
  int unsigned           cur_hp = 32'(lcr_pkg::RST_HALF_PERIOD);
  int unsigned           cur_tmo = lcr_pkg::RST_READY_TMO;
  int unsigned           cur_gain = 32'(lcr_pkg::RST_GAIN_PULSES);

  load_cell_adc_serial_reader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  lcr_readout_checker readout_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .words_o      (words_seen),
    .samples_o    (samples),
    .timeouts_o   (timeouts),
    .overruns_o   (overruns)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("load_cell_adc_serial_reader: mismatch");
      $finish;
    end
  end

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!steady && $urandom_range(0, 99) < 20) begin
        out_ready_i <= 1'b0;
        repeat (pick_pause()) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_tick(input logic d, input logic s);
    lcr_pkg::in_item_t w;
    int unsigned       gap;
    w.data_line = d;
    w.start_req = s;
    gap = (steady || $urandom_range(0, 99) < 65) ? 0 : pick_pause();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned hp, input int unsigned tmo,
                            input int unsigned lim, input int unsigned gain);
    write_reg(lcr_pkg::REG_HALF_PERIOD, hp);
    write_reg(lcr_pkg::REG_READY_TMO, tmo);
    write_reg(lcr_pkg::REG_FRAME_LIMIT, lim);
    write_reg(lcr_pkg::REG_GAIN_PULSES, gain);
    cur_hp   = hp;
    cur_tmo  = tmo;
    cur_gain = gain;
    settings_made++;
  endtask

  // Hold each data bit on the last tick of its high half; other shift ticks are random.
  task automatic read_frame(input logic [lcr_pkg::DATA_BITS-1:0] value,
                            input int unsigned high_ticks);
    int unsigned h;
    int unsigned ticks;
    int unsigned slot;
    h     = (cur_hp == 0) ? 1 : cur_hp;
    ticks = 2 * h * (lcr_pkg::DATA_BITS + cur_gain);
    send_tick(1'($urandom_range(0, 1)), 1'b1);
    for (int unsigned i = 0; i < high_ticks; i++) begin
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      if (i == cur_tmo) return;
    end
    send_tick(1'b0, 1'($urandom_range(0, 1)));
    for (int unsigned t = 0; t < ticks; t++) begin
      slot = t / (2 * h);
      if (t % (2 * h) == h - 1 && slot < lcr_pkg::DATA_BITS) begin
        send_tick(value[lcr_pkg::DATA_BITS-1-slot], 1'($urandom_range(0, 1)));
      end else begin
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned target;
    int unsigned h;
    int unsigned g;
    int unsigned len;
    int unsigned lim;
    int unsigned tmo;
    int unsigned reads;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    repeat (2) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    read_frame(24'h5AC396, 2);
    set_config(1, 0, 32'(lcr_pkg::RST_FRAME_LIMIT), 3);
    read_frame(24'h7FFFFF, 1);
    read_frame(24'h7FFFFF, 0);
    read_frame(24'h800000, 0);
    set_config(0, 32'hFFFF_FFFF, 0, 0);
    read_frame(24'hFFFFFF, 3);
    set_config(1, 2, 50, 1);
    read_frame(24'h000000, 2);
    read_frame(24'h000001, 3);
    set_config(1, 2, 49, 1);
    read_frame(lcr_pkg::DATA_BITS'($urandom), 0);
    // shrink the half period while a slow frame is in its first high half
    set_config(1023, lcr_pkg::RST_READY_TMO, 32'(lcr_pkg::FRAME_MAX), 2);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (30) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    write_reg(lcr_pkg::REG_HALF_PERIOD, 1);
    cur_hp = 1;
    repeat (60) send_tick(1'($urandom_range(0, 1)), 1'b0);

    target = words_sent + RANDOM_TICKS;
    while (words_sent < target) begin
      steady = ($urandom_range(0, 3) == 0);
      h   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
      g   = $urandom_range(0, 3);
      len = 2 * ((h == 0) ? 1 : h) * (lcr_pkg::DATA_BITS + g);
      case ($urandom_range(0, 4))
        0:       lim = 0;
        1:       lim = 32'(lcr_pkg::FRAME_MAX);
        2:       lim = len - 1;
        3:       lim = len;
        default: lim = $urandom_range(len / 2, 2 * len);
      endcase
      case ($urandom_range(0, 4))
        0:       tmo = 0;
        1:       tmo = 32'hFFFF_FFFF;
        2:       tmo = $urandom_range(1, 6);
        3:       tmo = lcr_pkg::RST_READY_TMO;
        default: tmo = $urandom_range(0, 3);
      endcase
      set_config(h, tmo, lim, g);
      reads = $urandom_range(3, 8);
      while (reads != 0 && words_sent < target) begin
        if ($urandom_range(0, 99) < 80) begin
          read_frame(lcr_pkg::DATA_BITS'($urandom), $urandom_range(0, 8));
        end else begin
          repeat ($urandom_range(5, 25)) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end
        repeat ($urandom_range(0, 2)) send_tick(1'($urandom_range(0, 1)), 1'b0);
        reads--;
      end
    end

    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d tick words over %0d register settings; %0d output words checked.",
             words_sent, settings_made, words_seen);
    $display("Reads ended with %0d samples, %0d wait timeouts and %0d frame overruns.",
             samples, timeouts, overruns);
    if (mismatches == 0) begin
      $display("load_cell_adc_serial_reader: match");
    end else begin
      $display("load_cell_adc_serial_reader: mismatch");
    end
    $finish;
  end

endmodule
